// ----- hw/rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam int DVS_W     = 16;
   localparam int PCT_SCALE = 100;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_NO_ROOM,
      STATUS_NULL_OR_FREE,
      STATUS_OUTSIDE,
      STATUS_ZERO_SIZE
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ALLOC,
      ST_SCAN,
      ST_WRITE,
      ST_GRANT,
      ST_FREE,
      ST_FDIV,
      ST_FCHK,
      ST_CLEAR,
      ST_PCT,
      ST_PDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        command;
      logic [31:0] request_bytes;
      logic [31:0] release_address;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] granted_address;
      logic [6:0]  free_percent;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [31:0]      dividend;
      logic [DVS_W-1:0] divisor;
      logic [31:0]      recip;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

// ----- hw/rtl/ffba_table.sv -----
// ----------------------------------------------------------------------------
// ffba_table
// Block table RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_table #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ffba_div.sv -----
// ----------------------------------------------------------------------------
// ffba_div
// Divide by a constant: reciprocal multiply, then one compare-and-correct
// step. Operand, product and estimate registers feed quotient and done.
// ----------------------------------------------------------------------------
module ffba_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ffba_pkg::div_req_type div_req,
   output ffba_pkg::div_rsp_type div_rsp
);
   import ffba_pkg::*;

   logic             s1_ff, s1_in;
   logic             s2_ff, s2_in;
   logic             s3_ff, s3_in;
   logic             done_ff, done_in;
   logic [31:0]      num_ff, num_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [31:0]      rcp_ff, rcp_in;
   logic [63:0]      prod_ff, prod_in;
   logic [31:0]      est_ff, est_in;
   logic [31:0]      back_ff, back_in;
   logic [31:0]      quo_ff, quo_in;
   logic [31:0]      rem;

   // estimate is exact or one low; the remainder check fixes it
   always_comb begin
      s1_in   = div_req.start;
      s2_in   = s1_ff;
      s3_in   = s2_ff;
      done_in = s3_ff;
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      rcp_in  = rcp_ff;
      if (div_req.start) begin
         num_in = div_req.dividend;
         dvs_in = div_req.divisor;
         rcp_in = div_req.recip;
      end
      prod_in = {32'd0, num_ff} * {32'd0, rcp_ff};
      est_in  = prod_ff[63:32];
      back_in = prod_ff[63:32] * 32'(dvs_ff);
      rem     = num_ff - back_ff;
      quo_in  = quo_ff;
      if (s3_ff) begin
         quo_in = (rem >= 32'(dvs_ff)) ? est_ff + 32'd1 : est_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         s3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      dvs_ff  <= dvs_in;
      rcp_ff  <= rcp_in;
      prod_ff <= prod_in;
      est_ff  <= est_in;
      back_ff <= back_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- hw/rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a RAM table of fixed-size blocks.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_data    (ffba_pkg::req_type)
//   rsp      out  rsp_valid / rsp_stall  rsp_data    (ffba_pkg::rsp_type)
//   csr      in   csr_wr_en              csr_wr_data (pool base address)
//
// After reset the table is cleared, one entry a cycle, with req_stall high.
// One transaction at a time: an allocate scans the table, then writes the
// run; a free divides the offset, then walks and clears the run; both end
// with the free-percent divide. The single table read port sets the walk
// rate, and no new request is taken until the result is loaded. A result waits
// in the output register; a stalled one holds the next result back.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int BLOCK_COUNT = 1024,
   parameter int BLOCK_BYTES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffba_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   import ffba_pkg::*;

   localparam int IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int CNT_W = $clog2(BLOCK_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(BLOCK_COUNT - 1);
   localparam logic [CNT_W-1:0] COUNT_FULL  = CNT_W'(BLOCK_COUNT);
   localparam logic [31:0]      BB32        = 32'(BLOCK_BYTES);
   localparam logic [31:0]      TOTAL_BYTES = 32'(BLOCK_COUNT * BLOCK_BYTES);
   localparam logic [31:0]      BB_RECIP    = 32'(64'hFFFF_FFFF / 64'(BLOCK_BYTES));
   localparam logic [31:0]      BC_RECIP    = 32'(64'hFFFF_FFFF / 64'(BLOCK_COUNT));

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [31:0]      rb_ff, rb_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] free_ff, free_in;
   status_type       status_ff, status_in;
   logic [31:0]      granted_ff, granted_in;
   logic [31:0]      prod_ff, prod_in;
   logic [6:0]       pct_ff, pct_in;
   logic [31:0]      base_ff, base_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [CNT_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [CNT_W-1:0] mem_rd_data;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic             accept;
   logic             load_rsp;
   logic [31:0]      offset;
   logic [CNT_W-1:0] run_next;
   logic [31:0]      rb_next;
   logic             found;

   ffba_table #(
      .DEPTH  (BLOCK_COUNT),
      .ADDR_W (IDX_W),
      .DATA_W (CNT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ffba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept   = req_valid && !req_stall;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign offset   = req_ff.release_address - base_ff;
   assign run_next = run_ff + 1'b1;
   assign rb_next  = rb_ff + BB32;
   assign found    = (mem_rd_data == '0) && (rb_next >= req_ff.request_bytes);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:  if (idx_ff == LAST_IDX) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.command == CMD_ALLOC) ? ST_ALLOC : ST_FREE;
            end
         end
         ST_ALLOC: begin
            if (req_ff.request_bytes == '0 || req_ff.request_bytes > TOTAL_BYTES) begin
               state_in = ST_PCT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_WRITE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_PCT;
            end
         end
         ST_WRITE: if (cnt_ff == run_ff - 1'b1) state_in = ST_GRANT;
         ST_GRANT: state_in = ST_PCT;
         ST_FREE: begin
            if (req_ff.release_address == '0 || req_ff.release_address < base_ff ||
                offset >= TOTAL_BYTES) begin
               state_in = ST_PCT;
            end else begin
               state_in = ST_FDIV;
            end
         end
         ST_FDIV:  if (div_rsp.done) state_in = ST_FCHK;
         ST_FCHK: begin
            if (mem_rd_data != '0 && mem_rd_data > CNT_W'(1) && idx_ff != LAST_IDX) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_PCT;
            end
         end
         ST_CLEAR: begin
            if (!(cnt_ff + 1'b1 < len_ff && idx_ff != LAST_IDX)) state_in = ST_PCT;
         end
         ST_PCT:   state_in = ST_PDIV;
         ST_PDIV:  if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:  if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      req_in       = req_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      rb_in        = rb_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      prod_in      = prod_ff;
      pct_in       = pct_ff;
      base_in      = csr_wr_en ? csr_wr_data : base_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff + 1'b1;
      div_req      = '{start: 1'b0, dividend: offset, divisor: DVS_W'(BLOCK_BYTES),
                       recip: BB_RECIP};
      case (state_ff)
         ST_INIT: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               status_in  = STATUS_OK;
               granted_in = '0;
            end
         end
         ST_ALLOC: begin
            if (req_ff.request_bytes == '0) begin
               status_in = STATUS_ZERO_SIZE;
            end else if (req_ff.request_bytes > TOTAL_BYTES) begin
               status_in = STATUS_NO_ROOM;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               idx_in      = '0;
               run_in      = '0;
               rb_in       = '0;
            end
         end
         ST_SCAN: begin
            if (mem_rd_data == '0) begin
               run_in = run_next;
               rb_in  = rb_next;
               if (run_ff == '0) start_in = idx_ff;
            end else begin
               run_in = '0;
               rb_in  = '0;
            end
            if (found) begin
               cnt_in = '0;
               idx_in = (run_ff == '0) ? idx_ff : start_ff;
            end else if (idx_ff == LAST_IDX) begin
               status_in = STATUS_NO_ROOM;
            end else begin
               mem_rd_en = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (cnt_ff == '0) ? run_ff : CNT_W'(1);
            prod_in     = 32'(start_ff) * BB32;
            if (cnt_ff == run_ff - 1'b1) begin
               free_in = free_ff - run_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_GRANT: granted_in = base_ff + prod_ff;
         ST_FREE: begin
            if (req_ff.release_address == '0) begin
               status_in = STATUS_NULL_OR_FREE;
            end else if (req_ff.release_address < base_ff || offset >= TOTAL_BYTES) begin
               status_in = STATUS_OUTSIDE;
            end else begin
               div_req.start = 1'b1;
            end
         end
         ST_FDIV: begin
            if (div_rsp.done) begin
               idx_in      = div_rsp.quotient[IDX_W-1:0];
               mem_rd_en   = 1'b1;
               mem_rd_addr = div_rsp.quotient[IDX_W-1:0];
            end
         end
         ST_FCHK: begin
            if (mem_rd_data == '0) begin
               status_in = STATUS_NULL_OR_FREE;
            end else begin
               len_in    = mem_rd_data;
               mem_wr_en = 1'b1;
               free_in   = free_ff + 1'b1;
               cnt_in    = CNT_W'(1);
               if (mem_rd_data > CNT_W'(1) && idx_ff != LAST_IDX) begin
                  mem_rd_en = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            if (mem_rd_data != '0) begin
               mem_wr_en = 1'b1;
               free_in   = free_ff + 1'b1;
            end
            if (cnt_ff + 1'b1 < len_ff && idx_ff != LAST_IDX) begin
               mem_rd_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
         end
         ST_PCT: begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(free_ff) * 32'(PCT_SCALE);
            div_req.divisor  = DVS_W'(BLOCK_COUNT);
            div_req.recip    = BC_RECIP;
         end
         ST_PDIV: if (div_rsp.done) pct_in = div_rsp.quotient[6:0];
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_ff, granted_address: granted_ff,
                                free_percent: pct_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         free_ff      <= COUNT_FULL;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         free_ff      <= free_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      start_ff   <= start_in;
      run_ff     <= run_in;
      rb_ff      <= rb_in;
      len_ff     <= len_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      prod_ff    <= prod_in;
      pct_ff     <= pct_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= COUNT_FULL)
      else $error("free block count exceeds pool size");

   a_rw_same_addr: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("table read and write hit the same entry");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> cnt_ff < run_ff && run_ff != '0)
      else $error("run write past its length");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

endmodule

// ----- verif/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A behavioral copy of
// the block table predicts status, granted address and free percentage for
// every accepted request. Directed cases cover size and address corners and
// address wrap. Random traffic follows, mostly alloc/free of live runs,
// under several pool base settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
   import ffba_pkg::*;

   localparam int BLOCK_COUNT  = 1024;
   localparam int BLOCK_BYTES  = 32;
   localparam int POOL_BYTES   = BLOCK_COUNT * BLOCK_BYTES;
   localparam int DRAIN_CYCLES = 2500;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // predicted allocator state
   int unsigned run_len [BLOCK_COUNT];
   int unsigned free_count;
   logic [31:0] base_addr;

   int unsigned live_heads[$];
   logic [31:0] released_addrs[$];
   rsp_type     pending_replies[$];
   int          errors = 0;
   int          req_left = 0;
   int          rsp_left = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   first_fit_block_allocator #(
      .BLOCK_COUNT(BLOCK_COUNT),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   function automatic int pick_wait(inout int left, inout bit calm);
      if (left == 0) begin
         left = $urandom_range(8, 48);
         calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic rsp_type predict_grant(input logic [31:0] bytes);
      rsp_type         r;
      longint unsigned need;
      int unsigned     blocks;
      int              i;
      int              run;
      int              head;
      bit              found;
      r = '0;
      run = 0;
      head = 0;
      found = 1'b0;
      if (bytes == 32'd0) begin
         r.status = STATUS_ZERO_SIZE;
      end else begin
         need = ({32'd0, bytes} + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
         if (need > 64'(BLOCK_COUNT)) begin
            r.status = STATUS_NO_ROOM;
         end else begin
            blocks = 32'(need);
            for (i = 0; i < BLOCK_COUNT; i++) begin
               if (run_len[i] == 0) begin
                  if (run == 0) head = i;
                  run++;
                  if (run >= blocks) begin
                     found = 1'b1;
                     break;
                  end
               end else begin
                  run = 0;
               end
            end
            if (!found) begin
               r.status = STATUS_NO_ROOM;
            end else begin
               for (i = head; i < head + blocks; i++) run_len[i] = 1;
               run_len[head] = blocks;
               free_count -= blocks;
               r.status = STATUS_OK;
               r.granted_address = base_addr + 32'(head * BLOCK_BYTES);
               live_heads.push_back(head);
            end
         end
      end
      r.free_percent = 7'((free_count * 100) / BLOCK_COUNT);
      return r;
   endfunction

   function automatic rsp_type predict_release(input logic [31:0] addr);
      rsp_type     r;
      logic [31:0] offset;
      int unsigned idx;
      int unsigned len;
      int unsigned j;
      r = '0;
      if (addr == 32'd0) begin
         r.status = STATUS_NULL_OR_FREE;
      end else if (addr < base_addr) begin
         r.status = STATUS_OUTSIDE;
      end else begin
         offset = addr - base_addr;
         idx = offset / BLOCK_BYTES;
         if (idx >= BLOCK_COUNT) begin
            r.status = STATUS_OUTSIDE;
         end else if (run_len[idx] == 0) begin
            r.status = STATUS_NULL_OR_FREE;
         end else begin
            len = run_len[idx];
            for (j = 0; j < len && idx + j < BLOCK_COUNT; j++) begin
               if (run_len[idx + j] != 0) begin
                  run_len[idx + j] = 0;
                  free_count++;
               end
            end
            r.status = STATUS_OK;
         end
      end
      r.free_percent = 7'((free_count * 100) / BLOCK_COUNT);
      return r;
   endfunction

   function automatic req_type alloc_req(input logic [31:0] bytes);
      req_type r;
      r.command = CMD_ALLOC;
      r.request_bytes = bytes;
      r.release_address = $urandom();
      return r;
   endfunction

   function automatic req_type free_req(input logic [31:0] addr);
      req_type r;
      r.command = CMD_FREE;
      r.request_bytes = $urandom();
      r.release_address = addr;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want_val);
      $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want_val);
      errors++;
   endtask

   // called at a clock edge; valid is kept high across back-to-back items
   task automatic send_request(input req_type item);
      int      gap;
      rsp_type want;
      gap = pick_wait(req_left, req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (item.command == CMD_ALLOC) begin
         want = predict_grant(item.request_bytes);
      end else begin
         want = predict_release(item.release_address);
         if (want.status == STATUS_OK) begin
            released_addrs.push_back(item.release_address);
            if (released_addrs.size() > 32) void'(released_addrs.pop_front());
         end
      end
      pending_replies.push_back(want);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pool_base(input logic [31:0] value);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_addr = value;
   endtask

   task automatic test_edge_cases();
      logic [31:0] b;
      b = 32'h0000_1000;
      write_pool_base(b);
      send_request(alloc_req(32'd0));
      send_request(alloc_req(32'hFFFF_FFFF));
      send_request(alloc_req(32'd1));
      send_request(alloc_req(32'd32));
      send_request(alloc_req(32'd33));
      send_request(free_req(32'd0));
      send_request(free_req(b - 1));
      send_request(free_req(b + POOL_BYTES));
      send_request(free_req(b + POOL_BYTES - 1));
      send_request(free_req(b + 2 * BLOCK_BYTES + 5));
      send_request(free_req(b + 2 * BLOCK_BYTES));
      send_request(alloc_req(POOL_BYTES));
      send_request(free_req(b + BLOCK_BYTES));
      send_request(free_req(b));
      send_request(alloc_req(POOL_BYTES));
      send_request(alloc_req(32'd1));
      // interior entry first, then head: interior stays cleared
      send_request(free_req(b + 5 * BLOCK_BYTES + 31));
      send_request(free_req(b + 5 * BLOCK_BYTES));
      send_request(free_req(b));
      send_request(alloc_req(POOL_BYTES + 1));
   endtask

   task automatic test_address_wrap();
      write_pool_base(32'hFFFF_FFE0);
      send_request(alloc_req(32'd1));
      send_request(alloc_req(32'd40));
      send_request(free_req(32'd0));
      send_request(free_req(32'h0000_0010));
      send_request(free_req(32'hFFFF_FFE5));
      send_request(free_req(32'hFFFF_FFFF));
   endtask

   task automatic test_random_traffic(input logic [31:0] pool_base, input int count);
      req_type     item;
      logic [31:0] bytes;
      logic [31:0] addr;
      int          pick;
      int          alloc_share;
      int          k;
      int unsigned head;
      int unsigned len;
      write_pool_base(pool_base);
      repeat (count) begin
         alloc_share = (free_count > BLOCK_COUNT / 2) ? 55 : 35;
         if ($urandom_range(0, 99) < alloc_share) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      bytes = $urandom_range(1, 6 * BLOCK_BYTES);
            else if (pick < 80) bytes = $urandom_range(1, 64 * BLOCK_BYTES);
            else if (pick < 86) bytes = 32'd0;
            else if (pick < 93) bytes = $urandom_range(POOL_BYTES - 8 * BLOCK_BYTES,
                                                       POOL_BYTES + BLOCK_BYTES);
            else                bytes = $urandom();
            item = alloc_req(bytes);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && live_heads.size() != 0) begin
               k = $urandom_range(0, live_heads.size() - 1);
               head = live_heads[k];
               live_heads.delete(k);
               addr = base_addr + 32'(head * BLOCK_BYTES) + $urandom_range(0, BLOCK_BYTES - 1);
            end else if (pick < 70 && live_heads.size() != 0) begin
               head = live_heads[$urandom_range(0, live_heads.size() - 1)];
               len = run_len[head];
               if (len > 1) head += $urandom_range(1, len - 1);
               addr = base_addr + 32'(head * BLOCK_BYTES);
            end else if (pick < 78 && released_addrs.size() != 0) begin
               addr = released_addrs[$urandom_range(0, released_addrs.size() - 1)];
            end else if (pick < 84) begin
               addr = 32'd0;
            end else if (pick < 92) begin
               if ($urandom_range(0, 1) == 0)
                  addr = base_addr - $urandom_range(1, 4096);
               else
                  addr = base_addr + POOL_BYTES + $urandom_range(0, 4096);
            end else begin
               addr = $urandom();
            end
            item = free_req(addr);
         end
         send_request(item);
      end
   endtask

   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = pick_wait(rsp_left, rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("result with no transaction pending",
                            rsp_data.granted_address, 32'd0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.granted_address !== want.granted_address)
               report_mismatch("granted_address", rsp_data.granted_address,
                               want.granted_address);
            if (rsp_data.free_percent !== want.free_percent)
               report_mismatch("free_percent", 32'(rsp_data.free_percent),
                               32'(want.free_percent));
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < BLOCK_COUNT; i++) run_len[i] = 0;
      free_count = BLOCK_COUNT;
      base_addr = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // table clear runs after reset
      do @(posedge clock); while (req_stall !== 1'b0);
      test_edge_cases();
      test_address_wrap();
      test_random_traffic(32'h0000_0000, 140);
      test_random_traffic(32'hFFFF_8000, 110);
      test_random_traffic($urandom(), 110);
      test_random_traffic(32'hFFFF_FFFF, 60);
      test_random_traffic({12'd0, 8'($urandom_range(1, 255)), 12'd0}, 140);
      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #70_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
